// ===== rtl/scl_pkg.sv =====
// scl_pkg: types, codes and command names for the serial command line parser
// used by every module under rtl; no dependencies

package scl_pkg;

   localparam int MAX_LINE_DEF = 11;
   localparam int NAME_LEN     = 5;
   localparam int NAME_W       = 8 * NAME_LEN;
   localparam int CMD_COUNT    = 9;
   localparam logic [15:0] VALUE_LIMIT_RST = 16'd50296;

   localparam logic [3:0] CMD_RDALL = 4'd0;
   localparam logic [3:0] CMD_WRMDL = 4'd4;
   localparam logic [3:0] CMD_WRRNG = 4'd5;
   localparam logic [3:0] CMD_NONE  = 4'd9;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [1:0] {
      ST_MORE  = 2'd0,
      ST_ERR   = 2'd1,
      ST_OK    = 2'd2,
      ST_QUIET = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CLS_LETTER,
      CLS_SIGN,
      CLS_DIGIT,
      CLS_CR,
      CLS_LF,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [7:0]     ch;
      logic [3:0]     digit;
      logic           minus;
   } char_info_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  command;
      logic [15:0] value;
   } result_type;

   // byte k of the name sits at bits 8k+7:8k
   function automatic logic [NAME_W-1:0] name_pack(input logic [NAME_W-1:0] s);
      logic [NAME_W-1:0] r;
      r = '0;
      for (int k = 0; k < NAME_LEN; k++) begin
         r[8*k +: 8] = s[8*(NAME_LEN-1-k) +: 8];
      end
      return r;
   endfunction

   localparam logic [NAME_W-1:0] CMD_NAMES [CMD_COUNT] = '{
      name_pack("RDALL"), name_pack("SWRST"), name_pack("PMCLR"),
      name_pack("SETIM"), name_pack("WRMDL"), name_pack("WRRNG"),
      name_pack("ENDSP"), name_pack("DSDSP"), name_pack("ENJKN")
   };

endpackage

// ===== rtl/scl_classify.sv =====
// scl_classify: folds case and sorts one received byte into a character class
// depends on scl_pkg

module scl_classify
   import scl_pkg::*;
(
   input  logic [7:0]    rx_byte,
   output char_info_type info
);

   logic [7:0] folded;

   always_comb begin
      folded = rx_byte;
      if (rx_byte >= 8'h61 && rx_byte <= 8'h7A) begin
         folded = rx_byte - 8'h20;
      end
      info.ch    = folded;
      info.digit = folded[3:0];
      info.minus = (folded == 8'h2D);
      if (folded >= 8'h41 && folded <= 8'h5A) begin
         info.cls = CLS_LETTER;
      end else if (folded == 8'h2B || folded == 8'h2D) begin
         info.cls = CLS_SIGN;
      end else if (folded >= 8'h30 && folded <= 8'h39) begin
         info.cls = CLS_DIGIT;
      end else if (folded == CHAR_CR) begin
         info.cls = CLS_CR;
      end else if (folded == CHAR_LF) begin
         info.cls = CLS_LF;
      end else begin
         info.cls = CLS_OTHER;
      end
   end

endmodule

// ===== rtl/scl_line.sv =====
// scl_line: line state registers and the per-byte result of the parser
// depends on scl_pkg

module scl_line
   import scl_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  char_info_type info,
   input  logic [15:0]   value_limit,
   output result_type    result
);

   localparam int LINE_CAP = MAX_LINE + 2;
   localparam int POS_W    = $clog2(LINE_CAP + 1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [1:0]        cr_ff, cr_in;
   logic [15:0]       accum_ff, accum_in;
   logic              neg_ff, neg_in;
   logic              closed_ff, closed_in;

   logic [POS_W-1:0]  pos_inc;
   logic [NAME_W-1:0] name_put;
   logic [3:0]        match_idx;
   logic              match_hit;
   logic [15:0]       signed_value;
   logic              clear;

   assign pos_inc      = pos_ff + 1'b1;
   assign signed_value = neg_ff ? (16'd0 - accum_ff) : accum_ff;

   always_comb begin
      name_put = name_ff;
      for (int k = 0; k < NAME_LEN; k++) begin
         if (pos_ff == POS_W'(k)) begin
            name_put[8*k +: 8] = info.ch;
         end
      end
   end

   always_comb begin
      match_idx = CMD_NONE;
      match_hit = 1'b0;
      for (int i = CMD_COUNT - 1; i >= 0; i--) begin
         if (name_ff == CMD_NAMES[i]) begin
            match_idx = 4'(i);
            match_hit = 1'b1;
         end
      end
   end

   always_comb begin
      pos_in         = pos_ff;
      name_in        = name_ff;
      cr_in          = cr_ff;
      accum_in       = accum_ff;
      neg_in         = neg_ff;
      closed_in      = closed_ff;
      clear          = 1'b0;
      result.status  = ST_MORE;
      result.command = CMD_NONE;
      result.value   = 16'd0;
      case (info.cls)
         CLS_LETTER: begin
            if (pos_ff < POS_W'(NAME_LEN)) begin
               name_in = name_put;
               pos_in  = pos_inc;
            end else begin
               clear = 1'b1;
            end
         end
         CLS_SIGN: begin
            if (pos_ff == POS_W'(NAME_LEN)) begin
               pos_in = pos_inc;
               if (!closed_ff) begin
                  neg_in = info.minus;
               end
            end else begin
               clear = 1'b1;
            end
         end
         CLS_DIGIT: begin
            if (pos_ff >= POS_W'(NAME_LEN) && pos_ff < POS_W'(MAX_LINE)) begin
               pos_in = pos_inc;
               if (!closed_ff) begin
                  accum_in = {accum_ff[12:0], 3'b000} + {accum_ff[14:0], 1'b0}
                             + {12'd0, info.digit};
               end
            end else begin
               clear = 1'b1;
            end
         end
         CLS_CR: begin
            if (pos_ff < POS_W'(LINE_CAP)) begin
               name_in   = name_put;
               pos_in    = pos_inc;
               closed_in = 1'b1;
               if (cr_ff != 2'd3) begin
                  cr_in = cr_ff + 2'd1;
               end
            end else begin
               clear = 1'b1;
            end
         end
         CLS_LF: begin
            clear = 1'b1;
            if (pos_ff < POS_W'(LINE_CAP) && cr_ff == 2'd1 && match_hit) begin
               result.command = match_idx;
               if (match_idx == CMD_RDALL) begin
                  result.status = ST_QUIET;
               end else if (match_idx == CMD_WRMDL || match_idx == CMD_WRRNG) begin
                  result.value  = signed_value;
                  result.status = (signed_value <= value_limit) ? ST_OK : ST_ERR;
               end else begin
                  result.status = ST_OK;
               end
            end
         end
         default: begin
            clear = 1'b1;
         end
      endcase
      if (clear) begin
         if (result.status == ST_MORE) begin
            result.status = ST_ERR;
         end
         pos_in    = '0;
         name_in   = '0;
         cr_in     = 2'd0;
         accum_in  = 16'd0;
         neg_in    = 1'b0;
         closed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         name_ff   <= '0;
         cr_ff     <= 2'd0;
         accum_ff  <= 16'd0;
         neg_ff    <= 1'b0;
         closed_ff <= 1'b0;
      end else if (step) begin
         pos_ff    <= pos_in;
         name_ff   <= name_in;
         cr_ff     <= cr_in;
         accum_ff  <= accum_in;
         neg_ff    <= neg_in;
         closed_ff <= closed_in;
      end
   end

endmodule

// ===== rtl/serial_command_line_parser.sv =====
// serial_command_line_parser: top level, input register, result register and
// the threshold register; depends on scl_pkg, scl_classify and scl_line
//
// One beat on req_ carries one received byte; every byte gives exactly one
// beat on rsp_ with a status, the matched command and the parsed value.
// Status 0 means the line continues, 1 error, 2 ok, 3 accepted silently.
// Lines are five letters, an optional sign, digits, then CR LF; a bad byte
// answers error and drops the line.
// csr_ writes the 16-bit threshold used by the two write commands; write it
// only while no byte is in flight. csr_ready is always high.
// A req_ beat passes through the input register, then the parse logic into
// the result register. Throughput is one byte per cycle while rsp_tready
// stays high. When rsp_tready is low the result register holds and the
// input register fills, after which req_tready drops until the sink takes
// the pending beat.
// Reset clears the line, both pipeline stages and restores the threshold
// to 50296.

module serial_command_line_parser
   import scl_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[1:0], command[5:2], value[21:6], zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // value_limit
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          out_valid_ff, out_valid_in;
   result_type    out_data_ff;
   logic [15:0]   limit_ff;
   logic          advance;
   char_info_type info;
   result_type    result;

   assign advance      = !out_valid_ff || rsp_tready;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;
   assign csr_ready    = 1'b1;

   scl_classify u_classify (
      .rx_byte (in_byte_ff),
      .info    (info)
   );

   scl_line #(
      .MAX_LINE (MAX_LINE)
   ) u_line (
      .clock       (clock),
      .reset       (reset),
      .step        (advance && in_valid_ff),
      .info        (info),
      .value_limit (limit_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= VALUE_LIMIT_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff.value, out_data_ff.command, out_data_ff.status};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for serial_command_line_parser, byte stream in, one result per byte
// predicts each result from its own line parser model; depends on scl_pkg and the rtl

module tb;
   import scl_pkg::*;

   localparam int LINE_MAX    = 11;
   localparam int LINE_CAP    = LINE_MAX + 2;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_MINUS = "-";

   typedef enum logic [3:0] {
      OP_RDALL, OP_SWRST, OP_PMCLR, OP_SETIM, OP_WRMDL,
      OP_WRRNG, OP_ENDSP, OP_DSDSP, OP_ENJKN, OP_NONE
   } op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // parser model state
   logic [4:0]  line_pos;
   logic [7:0]  name_q [NAME_LEN];
   logic [1:0]  cr_seen;
   logic [15:0] num;
   logic        num_neg;
   logic        num_done;
   logic [15:0] limit_q = VALUE_LIMIT_RST;

   result_type  replies_due [$];
   logic [7:0]  line_buf [$];
   int          errors = 0;
   int          bytes_sent = 0;
   int          line_count = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   logic        no_idle = 1'b0;
   logic        hold_on = 1'b0;
   event        hold_go;

   serial_command_line_parser #(.MAX_LINE(LINE_MAX)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [8*NAME_LEN-1:0] cmd_text(input op_type op);
      case (op)
         OP_RDALL: return "RDALL";
         OP_SWRST: return "SWRST";
         OP_PMCLR: return "PMCLR";
         OP_SETIM: return "SETIM";
         OP_WRMDL: return "WRMDL";
         OP_WRRNG: return "WRRNG";
         OP_ENDSP: return "ENDSP";
         OP_DSDSP: return "DSDSP";
         OP_ENJKN: return "ENJKN";
         default:  return '0;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic void clear_line();
      line_pos = '0;
      cr_seen  = '0;
      num      = '0;
      num_neg  = 1'b0;
      num_done = 1'b0;
      for (int k = 0; k < NAME_LEN; k++) name_q[k] = '0;
   endfunction

   function automatic void take_byte(input logic [7:0] c);
      if (line_pos < NAME_LEN) name_q[line_pos] = c;
      line_pos++;
   endfunction

   function automatic result_type parse_byte(input logic [7:0] rx);
      result_type r;
      logic [7:0] c;
      logic drop;
      logic hit;
      logic [8*NAME_LEN-1:0] txt;
      r.status  = ST_MORE;
      r.command = OP_NONE;
      r.value   = '0;
      drop = 1'b0;
      c = (rx >= "a" && rx <= "z") ? rx - 8'd32 : rx;
      if (c >= "A" && c <= "Z") begin
         if (line_pos < NAME_LEN) take_byte(c);
         else drop = 1'b1;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
         if (line_pos == NAME_LEN) begin
            line_pos++;
            if (!num_done) num_neg = (c == CH_MINUS);
         end else drop = 1'b1;
      end else if (c >= "0" && c <= "9") begin
         if (line_pos >= NAME_LEN && line_pos < LINE_MAX) begin
            line_pos++;
            if (!num_done) num = num * 16'd10 + 16'(c - "0");
         end else drop = 1'b1;
      end else if (c == CHAR_CR) begin
         if (line_pos < LINE_CAP) begin
            take_byte(c);
            num_done = 1'b1;
            if (cr_seen != 2'd3) cr_seen++;
         end else drop = 1'b1;
      end else if (c == CHAR_LF) begin
         drop = 1'b1;
         if (line_pos < LINE_CAP) begin
            take_byte(c);
            if (cr_seen == 2'd1 && line_pos >= NAME_LEN) begin
               for (int i = 0; i < CMD_COUNT; i++) begin
                  txt = cmd_text(op_type'(i));
                  hit = 1'b1;
                  for (int k = 0; k < NAME_LEN; k++)
                     if (name_q[k] != txt[8*(NAME_LEN-1-k) +: 8]) hit = 1'b0;
                  if (hit && r.command == OP_NONE) r.command = op_type'(i);
               end
               if (r.command == OP_RDALL) begin
                  r.status = ST_QUIET;
               end else if (r.command == OP_WRMDL || r.command == OP_WRRNG) begin
                  r.value  = num_neg ? 16'd0 - num : num;
                  r.status = (r.value <= limit_q) ? ST_OK : ST_ERR;
               end else if (r.command != OP_NONE) begin
                  r.status = ST_OK;
               end
            end
         end
      end else begin
         drop = 1'b1;
      end
      if (drop) begin
         if (r.status == ST_MORE) r.status = ST_ERR;
         clear_line();
      end
      return r;
   endfunction

   task automatic check_beat(input logic [23:0] d);
      result_type want;
      if (replies_due.size() == 0) begin
         $display("%0t: result beat with nothing expected, got %h", $time, d);
         errors++;
      end else begin
         want = replies_due.pop_front();
         if (d[1:0] !== want.status || d[5:2] !== want.command || d[21:6] !== want.value) begin
            $display("%0t: expected status %0d command %0d value %0d", $time,
                     want.status, want.command, want.value);
            $display("%0t: actual   status %0d command %0d value %0d", $time,
                     d[1:0], d[5:2], d[21:6]);
            errors++;
         end
      end
   endtask

   // result sink with random stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_beat(rsp_tdata);
      if (hold_on || stall_left > 0) begin
         rsp_tready <= 1'b0;
         if (stall_left > 0) stall_left <= stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // long receiver hold-off
   initial begin
      forever begin
         @(hold_go);
         hold_on <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] rx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      replies_due.push_back(parse_byte(rx));
      bytes_sent++;
   endtask

   task automatic send_buf();
      foreach (line_buf[i]) send_byte(line_buf[i]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_q = v;
      csr_valid <= 1'b0;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic end_line();
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
   endtask

   task automatic build_command_line();
      logic [8*NAME_LEN-1:0] txt;
      logic [7:0] c;
      logic has_sign;
      logic minus;
      int bad_pos;
      int target;
      int n;
      int mode;
      string digits;
      line_buf.delete();
      txt = cmd_text(op_type'(line_count % CMD_COUNT));
      line_count++;
      bad_pos = ($urandom_range(0, 99) < 85) ? NAME_LEN : int'($urandom_range(0, NAME_LEN - 1));
      for (int k = 0; k < NAME_LEN; k++) begin
         c = (k == bad_pos) ? 8'("A" + $urandom_range(0, 25)) : txt[8*(NAME_LEN-1-k) +: 8];
         if ($urandom_range(0, 1)) c = c | 8'h20;
         line_buf.push_back(c);
      end
      has_sign = ($urandom_range(0, 2) == 0);
      minus = 1'($urandom_range(0, 1));
      if (has_sign) line_buf.push_back(minus ? CH_MINUS : CH_PLUS);
      mode = $urandom_range(0, 4);
      digits = "";
      n = 0;
      case (mode)
         1: n = $urandom_range(0, 9);
         2: begin
            target = int'(limit_q) + int'($urandom_range(0, 4)) - 2;
            if (target < 0) target = 0;
            n = (has_sign && minus && target > 0) ? 65536 - target : target;
         end
         3: n = $urandom_range(0, 65535);
         4: n = $urandom_range(0, 999999);
         default: n = 0;
      endcase
      if (mode != 0) digits = $sformatf("%0d", n);
      add_text(digits);
      end_line();
   endtask

   task automatic build_broken_line();
      int kind;
      kind = $urandom_range(0, 5);
      build_command_line();
      case (kind)
         0: begin
            line_buf.delete();
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
         end
         1: line_buf.delete(line_buf.size() - 2);
         2: repeat ($urandom_range(1, 3)) line_buf.insert(line_buf.size() - 1, CHAR_CR);
         3: begin
            // cr inside the name, sometimes followed by a sign
            line_buf.delete();
            repeat ($urandom_range(0, 4)) line_buf.push_back(8'("A" + $urandom_range(0, 25)));
            line_buf.push_back(CHAR_CR);
            if ($urandom_range(0, 1)) begin
               line_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
               line_buf.push_back(8'("0" + $urandom_range(0, 9)));
               line_buf.push_back(CHAR_CR);
            end
            line_buf.push_back(CHAR_LF);
         end
         4: begin
            // full line of digits, then too many bytes for the buffer
            line_buf.delete();
            add_text("WRMDL");
            repeat (LINE_MAX - NAME_LEN) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
            repeat ($urandom_range(2, 3)) line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
         end
         default: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      endcase
   endtask

   task automatic run_lines(input int quota);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < quota) begin
         if ($urandom_range(0, 9) == 0) no_idle <= ~no_idle;
         if ($urandom_range(0, 99) < 70) build_command_line();
         else build_broken_line();
         send_buf();
      end
      no_idle <= 1'b0;
   endtask

   task automatic test_directed();
      line_buf.delete();
      add_text("WRMDL");
      end_line();
      add_text("wrrng-1");
      end_line();
      line_buf.push_back(8'h00);
      line_buf.push_back(8'h80);
      line_buf.push_back(8'hFF);
      line_buf.push_back(CHAR_LF);
      add_text("ab");
      end_line();
      send_buf();
   endtask

   task automatic test_default_threshold();
      run_lines(150);
   endtask

   task automatic test_threshold_extremes();
      write_limit(16'd0);
      run_lines(200);
      write_limit(16'hFFFF);
      run_lines(200);
   endtask

   task automatic test_random_thresholds();
      repeat (4) begin
         write_limit(16'($urandom_range(0, 65535)));
         run_lines(160);
      end
   endtask

   task automatic test_backpressure();
      wait_drained();
      no_idle <= 1'b1;
      -> hold_go;
      repeat (5) begin
         build_command_line();
         send_buf();
      end
      no_idle <= 1'b0;
   endtask

   initial begin
      clear_line();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_default_threshold();
      test_threshold_extremes();
      test_random_thresholds();
      test_backpressure();
      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
